[src/order_statistic_window_filter_assert.svh]
// assertion macros for the order statistic window filter
`ifndef ORDER_STATISTIC_WINDOW_FILTER_ASSERT_SVH
`define ORDER_STATISTIC_WINDOW_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define OSW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("osw check failed");
`define OSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("osw check failed");
`else
`define OSW_ASSERT_SAME(label, ante, cons)
`define OSW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[src/osw_pkg.sv]
// shared constants and types of the order statistic window filter
package osw_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int RING_ROWS = 5;
    localparam int COL_W = 10;
    localparam int RING_W = 3;
    localparam int ADDR_W = RING_W + COL_W;
    localparam int MEM_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int WIN_N = 9;

    localparam logic [1:0] MODE_MIDPOINT = 2'd1;
    localparam logic [1:0] MODE_TRIMMED = 2'd2;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_TRIM = 2'd1;
    localparam logic [1:0] CFG_WIDTH = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    localparam logic ACT_DRAIN = 1'b1;

    typedef struct packed {
        logic       vld;
        logic       first;
        logic       inimg;
        logic [3:0] slot;
        logic [7:0] data;
    } t_smp;
endpackage

[src/osw_line_mem.sv]
// ring of pixel rows, one write and one registered read port
module osw_line_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [osw_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                 i_wdata,
    input  logic                       i_re,
    input  logic [osw_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                 o_rdata
);
    logic [7:0] r_mem [0:osw_pkg::MEM_DEPTH-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/osw_stats.sv]
// window gather, odd-even sort, median or midpoint pick, trimmed sum and serial divide
module osw_stats (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  osw_pkg::t_smp i_smp,
    input  logic          i_start,
    input  logic [1:0]    i_mode,
    input  logic [3:0]    i_trim,
    output logic          o_done,
    output logic [7:0]    o_result
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SORT = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  r_st;
    logic [7:0]  r_win [0:osw_pkg::WIN_N-1];
    logic [7:0]  n_win [0:osw_pkg::WIN_N-1];
    logic [3:0]  r_n;
    logic [3:0]  r_cnt;
    logic [11:0] r_sum;
    logic [11:0] r_num;
    logic [4:0]  r_rem;
    logic [7:0]  r_quo;
    logic [7:0]  r_res;
    logic [2:0]  thalf;
    logic [2:0]  tcut;
    logic [3:0]  m_cnt;
    logic [3:0]  hi_lim;
    logic [11:0] n_sum;
    logic [4:0]  rem_sh;
    logic        rem_ge;
    logic [8:0]  mid_sum;

    always_comb begin
        thalf = i_trim[3:1];
        if ({thalf, 1'b0} >= r_n) begin
            tcut = 3'((r_n - 4'd1) >> 1);
        end else begin
            tcut = thalf;
        end
        m_cnt = r_n - {tcut, 1'b0};
        hi_lim = r_n - {1'b0, tcut};
        if (r_cnt >= {1'b0, tcut} && r_cnt < hi_lim) begin
            n_sum = r_sum + {4'd0, r_win[r_cnt]};
        end else begin
            n_sum = r_sum;
        end
        rem_sh = {r_rem[3:0], r_num[11]};
        rem_ge = rem_sh >= {1'b0, m_cnt};
        mid_sum = {1'b0, r_win[0]} + {1'b0, r_win[r_n - 4'd1]};
    end

    // one compare-exchange round, even or odd pairs
    always_comb begin
        for (int i = 0; i < osw_pkg::WIN_N; i++) begin
            n_win[i] = r_win[i];
        end
        for (int i = 0; i + 1 < osw_pkg::WIN_N; i++) begin
            if ((i % 2) == int'(r_cnt[0]) && r_win[i] > r_win[i+1]) begin
                n_win[i] = r_win[i+1];
                n_win[i+1] = r_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_n <= 4'd0;
            r_cnt <= 4'd0;
        end else begin
            if (i_smp.vld) begin
                r_win[i_smp.slot] <= i_smp.inimg ? i_smp.data : 8'hFF;
                r_n <= (i_smp.first ? 4'd0 : r_n) + {3'd0, i_smp.inimg};
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_st <= S_SORT;
                        r_cnt <= 4'd0;
                    end
                end
                S_SORT: begin
                    for (int i = 0; i < osw_pkg::WIN_N; i++) begin
                        r_win[i] <= n_win[i];
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(osw_pkg::WIN_N - 1)) begin
                        r_cnt <= 4'd0;
                        r_sum <= 12'd0;
                        if (i_mode == osw_pkg::MODE_TRIMMED) begin
                            r_st <= S_SUM;
                        end else if (i_mode == osw_pkg::MODE_MIDPOINT) begin
                            r_res <= 8'(n_win[0] / 2 + 0) ;
                            r_st <= S_DONE;
                        end else begin
                            r_st <= S_DONE;
                        end
                    end
                end
                S_SUM: begin
                    r_sum <= n_sum;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(osw_pkg::WIN_N - 1)) begin
                        r_num <= n_sum + {9'd0, m_cnt[3:1]};
                        r_rem <= 5'd0;
                        r_cnt <= 4'd0;
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_num <= {r_num[10:0], 1'b0};
                    r_rem <= rem_ge ? (rem_sh - {1'b0, m_cnt}) : rem_sh;
                    r_quo <= {r_quo[6:0], rem_ge};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd11) begin
                        r_res <= {r_quo[6:0], rem_ge};
                        r_st <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_st <= S_IDLE;
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_st == S_DONE);
    assign o_result = (i_mode == osw_pkg::MODE_TRIMMED) ? r_res :
                      (i_mode == osw_pkg::MODE_MIDPOINT) ? mid_sum[8:1] : r_win[r_n >> 1];
endmodule

[src/order_statistic_window_filter.sv]
// top level of the order statistic window filter
//  channel   dir  handshake                  payload
//  s         in   i_s_tvalid / o_s_tready    tdata pixel_value, tuser action
//  m         out  o_m_tvalid / i_m_tready    tdata filtered_value, tlast frame_end
//  cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
// an item that gives no result is taken straight from idle; one that gives a result
// is held by nine reads of the single line store port and the sort rounds, and in
// trimmed mean also by the serial divide
// one item is in work at a time; the input stalls until the result is taken
// synchronous reset clears counters and control; the line store is not cleared
module order_statistic_window_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // pixel_value
    input  logic        i_s_tuser,   // action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // filtered_value
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic [1:0]  r_mode;
    logic [3:0]  r_trim;
    logic [10:0] r_img_w;
    logic [12:0] r_img_h;
    logic [9:0]  r_col;
    logic [12:0] r_row;
    logic [2:0]  r_wring;
    logic [9:0]  r_ocol;
    logic [11:0] r_orow;
    logic [2:0]  r_oring;
    logic [10:0] r_pend;
    logic [3:0]  r_k;
    logic [1:0]  r_ky;
    logic [1:0]  r_kx;
    logic        r_rd_act;
    logic        r_rd_in;
    logic [3:0]  r_rd_slot;

    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [11:0] lag;
    logic        complete;
    logic        take;
    logic        px_in;
    logic [10:0] n_pend;
    logic        col_wrap;
    logic        last_out;
    logic        rd_issue;
    logic        y_in;
    logic        x_in;
    logic [2:0]  rd_ring;
    logic [9:0]  rd_x;
    logic [7:0]  mem_q;
    logic        st_done;
    logic [7:0]  st_res;
    logic        cfg_wr;
    logic        out_hs;
    osw_pkg::t_smp smp;

    always_comb begin
        if (r_img_w == 11'd0) begin
            w_eff = 11'd1;
        end else if (r_img_w > 11'(osw_pkg::MAX_WIDTH)) begin
            w_eff = 11'(osw_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_img_w;
        end
        if (r_img_h == 13'd0) begin
            h_eff = 13'd1;
        end else if (r_img_h > 13'(osw_pkg::MAX_HEIGHT)) begin
            h_eff = 13'(osw_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_img_h;
        end
        lag = {1'b0, w_eff} + 12'd1;
        complete = r_row >= h_eff;
        take = i_s_tvalid && o_s_tready;
        px_in = (i_s_tuser != osw_pkg::ACT_DRAIN) && !complete;
        n_pend = r_pend + 11'd1;
        col_wrap = ({1'b0, r_col} + 11'd1) >= w_eff;
        last_out = ({1'b0, r_orow} + 13'd1 >= h_eff) && ({1'b0, r_ocol} + 11'd1 >= w_eff);
        out_hs = o_m_tvalid && i_m_tready;
        cfg_wr = i_cfg_valid && o_cfg_ready;

        rd_issue = (r_state == ST_READ) && (r_k < 4'(osw_pkg::WIN_N));
        y_in = !((r_ky == 2'd0) && (r_orow == 12'd0)) &&
               !((r_ky == 2'd2) && ({1'b0, r_orow} + 13'd1 >= h_eff));
        x_in = !((r_kx == 2'd0) && (r_ocol == 10'd0)) &&
               !((r_kx == 2'd2) && ({1'b0, r_ocol} + 11'd1 >= w_eff));
        if (r_ky == 2'd0) begin
            rd_ring = (r_oring == 3'd0) ? 3'(osw_pkg::RING_ROWS - 1) : r_oring - 3'd1;
        end else if (r_ky == 2'd1) begin
            rd_ring = r_oring;
        end else begin
            rd_ring = (r_oring == 3'(osw_pkg::RING_ROWS - 1)) ? 3'd0 : r_oring + 3'd1;
        end
        rd_x = r_ocol + {8'd0, r_kx} - 10'd1;

        smp.vld = r_rd_act;
        smp.first = (r_rd_slot == 4'd0);
        smp.inimg = r_rd_in;
        smp.slot = r_rd_slot;
        smp.data = mem_q;
    end

    osw_line_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (take && px_in),
        .i_waddr ({r_wring, r_col}),
        .i_wdata (i_s_tdata),
        .i_re    (rd_issue),
        .i_raddr ({rd_ring, rd_x}),
        .o_rdata (mem_q)
    );

    osw_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp    (smp),
        .i_start  ((r_state == ST_READ) && (r_k == 4'(osw_pkg::WIN_N))),
        .i_mode   (r_mode),
        .i_trim   (r_trim),
        .o_done   (st_done),
        .o_result (st_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode <= 2'd0;
            r_trim <= 4'd2;
            r_img_w <= 11'd1024;
            r_img_h <= 13'd1024;
            r_col <= 10'd0;
            r_row <= 13'd0;
            r_wring <= 3'd0;
            r_ocol <= 10'd0;
            r_orow <= 12'd0;
            r_oring <= 3'd0;
            r_pend <= 11'd0;
            r_k <= 4'd0;
            r_ky <= 2'd0;
            r_kx <= 2'd0;
            r_rd_act <= 1'b0;
            r_rd_in <= 1'b0;
            r_rd_slot <= 4'd0;
        end else begin
            r_rd_act <= rd_issue;
            r_rd_in <= y_in && x_in;
            r_rd_slot <= r_k;
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        if (px_in) begin
                            r_pend <= n_pend;
                            if (col_wrap) begin
                                r_col <= 10'd0;
                                r_row <= r_row + 13'd1;
                                r_wring <= (r_wring == 3'(osw_pkg::RING_ROWS - 1)) ?
                                           3'd0 : r_wring + 3'd1;
                            end else begin
                                r_col <= r_col + 10'd1;
                            end
                            if ({1'b0, n_pend} > lag) begin
                                r_state <= ST_READ;
                            end
                        end else if (complete && r_pend != 11'd0) begin
                            r_state <= ST_READ;
                        end
                        r_k <= 4'd0;
                        r_ky <= 2'd0;
                        r_kx <= 2'd0;
                    end
                end
                ST_READ: begin
                    r_k <= r_k + 4'd1;
                    if (r_kx == 2'd2) begin
                        r_kx <= 2'd0;
                        r_ky <= r_ky + 2'd1;
                    end else begin
                        r_kx <= r_kx + 2'd1;
                    end
                    if (r_k == 4'(osw_pkg::WIN_N)) begin
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (st_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_m_tready) begin
                        r_state <= ST_IDLE;
                        r_pend <= r_pend - 11'd1;
                        if (last_out) begin
                            r_col <= 10'd0;
                            r_row <= 13'd0;
                            r_wring <= 3'd0;
                            r_ocol <= 10'd0;
                            r_orow <= 12'd0;
                            r_oring <= 3'd0;
                            r_pend <= 11'd0;
                        end else if ({1'b0, r_ocol} + 11'd1 >= w_eff) begin
                            r_ocol <= 10'd0;
                            r_orow <= r_orow + 12'd1;
                            r_oring <= (r_oring == 3'(osw_pkg::RING_ROWS - 1)) ?
                                       3'd0 : r_oring + 3'd1;
                        end else begin
                            r_ocol <= r_ocol + 10'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    osw_pkg::CFG_MODE:   r_mode <= i_cfg_data[1:0];
                    osw_pkg::CFG_TRIM:   r_trim <= i_cfg_data[3:0];
                    osw_pkg::CFG_WIDTH:  r_img_w <= i_cfg_data[10:0];
                    osw_pkg::CFG_HEIGHT: r_img_h <= i_cfg_data;
                    default:             r_mode <= r_mode;
                endcase
                if (i_cfg_index == osw_pkg::CFG_WIDTH || i_cfg_index == osw_pkg::CFG_HEIGHT) begin
                    r_col <= 10'd0;
                    r_row <= 13'd0;
                    r_wring <= 3'd0;
                    r_ocol <= 10'd0;
                    r_orow <= 12'd0;
                    r_oring <= 3'd0;
                    r_pend <= 11'd0;
                end
            end
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_m_tdata = st_res;
    assign o_m_tlast = last_out;
    assign o_cfg_ready = 1'b1;

`include "order_statistic_window_filter_assert.svh"
    `OSW_ASSERT_SAME(a_one_item, o_m_tvalid, !o_s_tready)
    `OSW_ASSERT_NEXT(a_frame_restart, out_hs && o_m_tlast, r_pend == 11'd0 && r_ocol == 10'd0)
    `OSW_ASSERT_SAME(a_read_range, r_state == ST_READ, r_k <= 4'(osw_pkg::WIN_N))
endmodule

[tb/sv/order_statistic_window_filter_tb.sv]
// testbench of the order statistic window filter: stimulus, prediction and result check
module order_statistic_window_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_MEDIAN = 2'd0;
    localparam logic [1:0] MODE_THREE = 2'd3;
    localparam logic ACT_PIXEL = ~osw_pkg::ACT_DRAIN;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_ITEMS = 1550;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_pix_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // pixel_value
    logic        i_s_tuser = 1'b0; // action
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;        // filtered_value
    logic        o_m_tlast;        // frame_end
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;

    order_statistic_window_filter u_top (.*);

    always #2 i_clk = ~i_clk;

    // model state
    logic [1:0]  cur_mode;
    logic [3:0]  cur_trim;
    logic [10:0] cur_width;
    logic [12:0] cur_height;
    logic [7:0]  pix_ring [0:osw_pkg::RING_ROWS*osw_pkg::MAX_WIDTH-1];
    int unsigned in_col, in_row, out_col, out_row, pend_pix;

    t_pix_out    filtered_q[$];
    int          errors = 0;
    int unsigned cycles = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    function automatic int unsigned frame_w();
        if (cur_width < 1) return 1;
        if (cur_width > osw_pkg::MAX_WIDTH) return osw_pkg::MAX_WIDTH;
        return cur_width;
    endfunction

    function automatic int unsigned frame_h();
        if (cur_height < 1) return 1;
        if (cur_height > osw_pkg::MAX_HEIGHT) return osw_pkg::MAX_HEIGHT;
        return cur_height;
    endfunction

    function automatic void restart_frame();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; pend_pix = 0;
    endfunction

    function automatic logic [7:0] window_stat();
        int unsigned w, h, n, t, sum;
        int y, x;
        logic [7:0] v [0:8];
        logic [7:0] tmp;
        w = frame_w(); h = frame_h(); n = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            y = int'(out_row) + dy;
            if (y < 0 || y >= int'(h)) continue;
            for (int dx = -1; dx <= 1; dx++) begin
                x = int'(out_col) + dx;
                if (x < 0 || x >= int'(w)) continue;
                v[n] = pix_ring[(y % osw_pkg::RING_ROWS) * osw_pkg::MAX_WIDTH + x];
                n++;
            end
        end
        for (int i = 1; i < n; i++)
            for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
                tmp = v[j]; v[j] = v[j-1]; v[j-1] = tmp;
            end
        case (cur_mode)
            osw_pkg::MODE_MIDPOINT: return 8'((9'(v[0]) + 9'(v[n-1])) >> 1);
            osw_pkg::MODE_TRIMMED: begin
                t = cur_trim / 2;
                if (2 * t >= n) t = (n - 1) / 2;
                sum = 0;
                for (int i = t; i < n - t; i++) sum += v[i];
                return 8'((sum + (n - 2 * t) / 2) / (n - 2 * t));
            end
            default: return v[n / 2];
        endcase
    endfunction

    function automatic void emit_pixel();
        t_pix_out r;
        r.value = window_stat();
        r.last = (out_row + 1 >= frame_h() && out_col + 1 >= frame_w());
        filtered_q = {filtered_q, r};
        if (pend_pix > 0) pend_pix--;
        if (r.last) begin
            restart_frame();
            return;
        end
        out_col++;
        if (out_col >= frame_w()) begin
            out_col = 0;
            out_row++;
        end
    endfunction

    function automatic void predict_item(logic act, logic [7:0] pix);
        int unsigned w, h;
        bit complete;
        w = frame_w(); h = frame_h();
        complete = (in_row >= h);
        if (act == ACT_PIXEL && !complete) begin
            pix_ring[(in_row % osw_pkg::RING_ROWS) * osw_pkg::MAX_WIDTH + in_col] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            pend_pix++;
            if (pend_pix > w + 1) emit_pixel();
        end else if (complete && pend_pix > 0) begin
            emit_pixel();
        end
    endfunction

    // gaps come between bursts of random length
    task automatic send_item(logic act, logic [7:0] pix);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= act;
        i_s_tdata <= pix;
        do @(posedge i_clk); while (!o_s_tready);
        predict_item(act, pix);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(40);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            osw_pkg::CFG_MODE: cur_mode = val[1:0];
            osw_pkg::CFG_TRIM: cur_trim = val[3:0];
            osw_pkg::CFG_WIDTH: begin cur_width = val[10:0]; restart_frame(); end
            default: begin cur_height = val; restart_frame(); end
        endcase
    endtask

    task automatic set_frame(logic [1:0] mode, logic [3:0] trim, logic [12:0] w,
                             logic [12:0] h);
        wait_idle();
        write_reg(osw_pkg::CFG_MODE, 13'(mode));
        write_reg(osw_pkg::CFG_TRIM, 13'(trim));
        write_reg(osw_pkg::CFG_WIDTH, w);
        write_reg(osw_pkg::CFG_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    // one frame, optional stray drains inside, then mostly drains until all outputs are out
    task automatic run_frame(int noise_pct, int extra);
        int unsigned total;
        total = frame_w() * frame_h();
        for (int unsigned k = 0; k < total; k++) begin
            if ($urandom_range(99) < noise_pct) send_item(osw_pkg::ACT_DRAIN, 8'($urandom));
            send_item(ACT_PIXEL, 8'($urandom));
        end
        while (pend_pix > 0)
            send_item(($urandom_range(4) == 0) ? ACT_PIXEL : osw_pkg::ACT_DRAIN,
                      8'($urandom));
        repeat (extra) send_item(1'($urandom), 8'($urandom));
    endtask

    task automatic test_directed();
        // default geometry: a few pixels, never reaches the lag
        for (int k = 0; k < 4; k++) send_item(ACT_PIXEL, 8'($urandom));
        send_item(osw_pkg::ACT_DRAIN, 8'h00);
        set_frame(MODE_MEDIAN, 4'd2, 13'd3, 13'd3);
        send_item(ACT_PIXEL, 8'hFF);
        send_item(ACT_PIXEL, 8'h00);
        send_item(osw_pkg::ACT_DRAIN, 8'hFF);
        for (int k = 0; k < 7; k++) send_item(ACT_PIXEL, (k % 2) ? 8'hFF : 8'h00);
        send_item(ACT_PIXEL, 8'hAA);
        repeat (4) send_item(osw_pkg::ACT_DRAIN, 8'h00);
        set_frame(osw_pkg::MODE_MIDPOINT, 4'd0, 13'd0, 13'd0);
        run_frame(0, 1);
        set_frame(osw_pkg::MODE_TRIMMED, 4'd15, 13'd1, 13'd1);
        run_frame(0, 1);
        set_frame(MODE_THREE, 4'd8, 13'd2, 13'd2);
        run_frame(20, 1);
    endtask

    task automatic test_geometry_extremes();
        set_frame(osw_pkg::MODE_TRIMMED, 4'd2, 13'h1FFF, 13'd1);
        for (int k = 0; k < 40; k++) send_item(ACT_PIXEL, 8'($urandom));
        send_item(osw_pkg::ACT_DRAIN, 8'h00);
        set_frame(osw_pkg::MODE_MIDPOINT, 4'd0, 13'd1, 13'h1FFF);
        for (int k = 0; k < 40; k++) send_item(ACT_PIXEL, 8'($urandom));
        set_frame(MODE_MEDIAN, 4'd2, 13'd1024, 13'd4096);
        for (int k = 0; k < 20; k++) send_item(ACT_PIXEL, 8'($urandom));
    endtask

    task automatic test_random_frames();
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_frame(2'($urandom), 4'($urandom), 13'($urandom_range(1, 12)),
                      13'($urandom_range(1, 8)));
            if ($urandom_range(7) == 0) begin
                for (int k = 0; k < 5; k++) send_item(1'($urandom), 8'($urandom));
                sent += 5;
                continue;
            end
            sent += frame_w() * frame_h() + frame_w() + 2;
            run_frame(($urandom_range(3) == 0) ? 15 : 0, $urandom_range(2));
        end
    endtask

    task automatic test_backpressure();
        set_frame(osw_pkg::MODE_TRIMMED, 4'd4, 13'd8, 13'd6);
        hold_req = 1'b1;
        run_frame(0, 0);
    endtask

    initial begin
        for (int k = 0; k < osw_pkg::RING_ROWS * osw_pkg::MAX_WIDTH; k++) pix_ring[k] = '0;
        cur_mode = MODE_MEDIAN; cur_trim = 4'd2;
        cur_width = 11'd1024; cur_height = 13'd1024;
        restart_frame();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_geometry_extremes();
        test_backpressure();
        test_random_frames();
        wait_idle();
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    // receiver: stall pattern is redrawn at regular steps of the cycle counter, plus one long hold-off
    int unsigned rx_phase = 0;
    int unsigned hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles % 64 == 0) rx_phase = $urandom_range(2);
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_phase)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= 1'($urandom);
                default: i_m_tready <= ($urandom_range(3) == 0);
            endcase
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (filtered_q.size() == 0) begin
                $error("filtered_value: no item expected, actual %0d", o_m_tdata);
                errors++;
            end else begin
                want = filtered_q.pop_front();
                if (o_m_tdata !== want.value) begin
                    $error("filtered_value: expected %0d actual %0d", want.value, o_m_tdata);
                    errors++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("frame_end: expected %0d actual %0d", want.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end
endmodule

[sim.f]
+incdir+src
src/osw_pkg.sv
src/osw_line_mem.sv
src/osw_stats.sv
src/order_statistic_window_filter.sv
tb/sv/order_statistic_window_filter_tb.sv
